// ----- sv/ireq_pkg.sv -----
`default_nettype none
package ireq_pkg;

  localparam int ACC_WIDTH_DEF = 32;
  localparam int SHIFT_W       = 5;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;
  localparam int OUT_W         = 8;
  localparam int REM_W         = 2 ** SHIFT_W;
  localparam int HALF_W        = REM_W / 2 + 1;

  localparam int Q_MAX     = 127;
  localparam int Q_MIN     = -128;
  localparam int Q_MIN_SYM = -127;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SHIFT = 2'd0;
  localparam reg_idx_t REG_MODE  = 2'd1;
  localparam reg_idx_t REG_SYM   = 2'd2;

  localparam logic MODE_NEAREST = 1'b0;
  localparam logic MODE_STOCH   = 1'b1;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift_amount;
    logic               rounding_mode;
    logic               symmetric_clip;
  } cfg_t;

endpackage
`default_nettype wire

// ----- sv/int8_requantize_shift.sv -----
`default_nettype none
// Channel  Handshake                         Payload
// input    start, busy                       in_accumulator
// result   out_valid                         out_quantized
// config   psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// A word is taken in every cycle in which start is high; busy is always low.
// Each result appears for one cycle, after its word has passed the register stages.
// The four register stages are magnitude, rounding offset, shift and saturation.
// Reset is synchronous and clears the configuration registers and the stage valid bits;
// the data registers are not reset. Results cannot be held off, so the pipeline never stalls.
module int8_requantize_shift #(
  parameter int ACC_WIDTH = ireq_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [ACC_WIDTH-1:0] in_accumulator,
  output logic                             out_valid,
  output logic signed [ireq_pkg::OUT_W-1:0] out_quantized,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ireq_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ireq_pkg::DATA_W-1:0] pwdata,
  output logic      [ireq_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import ireq_pkg::*;

  localparam int EW = ACC_WIDTH + REM_W + 1;

  cfg_t                  cfg;
  logic                  acc_vld;
  logic                  rnd_vld;
  logic signed [EW-1:0]  near_q;
  logic [ACC_WIDTH-1:0]  sto_q;
  logic                  sto_neg;
  logic [OUT_W-1:0]      q;

  assign busy    = 1'b0;
  assign acc_vld = start & ~busy;

  ireq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ireq_round #(.ACC_WIDTH(ACC_WIDTH), .EW(EW)) u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc_vld),
    .in_acc  (in_accumulator),
    .cfg     (cfg),
    .vld     (rnd_vld),
    .near_q  (near_q),
    .sto_q   (sto_q),
    .sto_neg (sto_neg)
  );

  ireq_clip #(.ACC_WIDTH(ACC_WIDTH), .EW(EW)) u_clip (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld     (rnd_vld),
    .near_q  (near_q),
    .sto_q   (sto_q),
    .sto_neg (sto_neg),
    .cfg     (cfg),
    .out_vld (out_valid),
    .out_q   (q)
  );

  assign out_quantized = q;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("Result strobe without a word taken four cycles earlier.");

  a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cfg.symmetric_clip) |-> (out_quantized != 8'sh80))
    else $error("Symmetric clipping produced -128.");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_accumulator == '0) |-> ##4 (out_valid && out_quantized == '0))
    else $error("Zero accumulator did not give a zero result.");
`endif

endmodule
`default_nettype wire

// ----- sv/ireq_cfg.sv -----
`default_nettype none
module ireq_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ireq_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ireq_pkg::DATA_W-1:0] pwdata,
  output logic      [ireq_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output ireq_pkg::cfg_t                  cfg
);
  import ireq_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SHIFT: cfg_nxt.shift_amount   = pwdata[SHIFT_W-1:0];
        REG_MODE:  cfg_nxt.rounding_mode  = pwdata[0];
        REG_SYM:   cfg_nxt.symmetric_clip = pwdata[0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SHIFT: prdata = DATA_W'(cfg_r.shift_amount);
      REG_MODE:  prdata = DATA_W'(cfg_r.rounding_mode);
      REG_SYM:   prdata = DATA_W'(cfg_r.symmetric_clip);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ireq_round.sv -----
`default_nettype none
module ireq_round #(
  parameter int ACC_WIDTH = ireq_pkg::ACC_WIDTH_DEF,
  parameter int EW        = ACC_WIDTH + ireq_pkg::REM_W + 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire logic signed [ACC_WIDTH-1:0] in_acc,
  input  wire ireq_pkg::cfg_t              cfg,
  output logic                             vld,
  output logic signed [EW-1:0]             near_q,
  output logic        [ACC_WIDTH-1:0]      sto_q,
  output logic                             sto_neg
);
  import ireq_pkg::*;

  logic                        s1_vld_r, s1_vld_nxt;
  logic signed [ACC_WIDTH-1:0] s1_acc_r, s1_acc_nxt;
  logic        [ACC_WIDTH-1:0] s1_mag_r, s1_mag_nxt;
  logic                        s1_neg_r, s1_neg_nxt;

  logic                        s2_vld_r, s2_vld_nxt;
  logic signed [EW-1:0]        s2_sum_r, s2_sum_nxt;
  logic        [ACC_WIDTH-1:0] s2_q0_r, s2_q0_nxt;
  logic                        s2_inc_r, s2_inc_nxt;
  logic                        s2_neg_r, s2_neg_nxt;

  logic                        s3_vld_r, s3_vld_nxt;
  logic signed [EW-1:0]        s3_near_r, s3_near_nxt;
  logic        [ACC_WIDTH-1:0] s3_sto_r, s3_sto_nxt;
  logic                        s3_neg_r, s3_neg_nxt;

  logic        [ACC_WIDTH-1:0] acc_u;
  logic signed [EW-1:0]        acc_e;
  logic        [EW-1:0]        half_e;
  logic        [EW-1:0]        mag_e;
  logic        [EW-1:0]        low_mask;
  logic        [REM_W-1:0]     rem;
  logic        [REM_W-1:0]     upper_w;
  logic        [SHIFT_W-2:0]   h;
  logic        [HALF_W-1:0]    hmask;
  logic        [HALF_W-1:0]    upper;
  logic        [HALF_W-1:0]    lower;
  logic        [HALF_W-1:0]    lower_d;

  always_comb begin
    acc_u      = in_acc;
    s1_vld_nxt = in_vld;
    s1_acc_nxt = in_acc;
    s1_neg_nxt = in_acc[ACC_WIDTH-1];
    s1_mag_nxt = s1_neg_nxt ? (ACC_WIDTH'(0) - acc_u) : acc_u;
  end

  always_comb begin
    acc_e      = {{(EW - ACC_WIDTH){s1_acc_r[ACC_WIDTH-1]}}, s1_acc_r};
    half_e     = (EW'(1) << cfg.shift_amount) >> 1;
    s2_sum_nxt = acc_e + half_e;

    mag_e    = EW'(s1_mag_r);
    low_mask = (EW'(1) << cfg.shift_amount) - EW'(1);
    rem      = mag_e[REM_W-1:0] & low_mask[REM_W-1:0];
    h        = cfg.shift_amount[SHIFT_W-1:1];
    hmask    = (HALF_W'(1) << h) - HALF_W'(1);
    upper_w  = rem >> h;
    upper    = upper_w[HALF_W-1:0];
    lower    = rem[HALF_W-1:0] & hmask;
    lower_d  = cfg.shift_amount[0] ? (lower << 1) : lower;

    s2_q0_nxt  = s1_mag_r >> cfg.shift_amount;
    s2_inc_nxt = upper > lower_d;
    s2_neg_nxt = s1_neg_r;
    s2_vld_nxt = s1_vld_r;
  end

  always_comb begin
    s3_vld_nxt  = s2_vld_r;
    s3_near_nxt = s2_sum_r >>> cfg.shift_amount;
    s3_sto_nxt  = s2_q0_r + ACC_WIDTH'(s2_inc_r);
    s3_neg_nxt  = s2_neg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
      s3_vld_r <= s3_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_acc_r  <= s1_acc_nxt;
    s1_mag_r  <= s1_mag_nxt;
    s1_neg_r  <= s1_neg_nxt;
    s2_sum_r  <= s2_sum_nxt;
    s2_q0_r   <= s2_q0_nxt;
    s2_inc_r  <= s2_inc_nxt;
    s2_neg_r  <= s2_neg_nxt;
    s3_near_r <= s3_near_nxt;
    s3_sto_r  <= s3_sto_nxt;
    s3_neg_r  <= s3_neg_nxt;
  end

  assign vld     = s3_vld_r;
  assign near_q  = s3_near_r;
  assign sto_q   = s3_sto_r;
  assign sto_neg = s3_neg_r;

endmodule
`default_nettype wire

// ----- sv/ireq_clip.sv -----
`default_nettype none
module ireq_clip #(
  parameter int ACC_WIDTH = ireq_pkg::ACC_WIDTH_DEF,
  parameter int EW        = ACC_WIDTH + ireq_pkg::REM_W + 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        vld,
  input  wire logic signed [EW-1:0]        near_q,
  input  wire logic        [ACC_WIDTH-1:0] sto_q,
  input  wire logic                        sto_neg,
  input  wire ireq_pkg::cfg_t              cfg,
  output logic                             out_vld,
  output logic        [ireq_pkg::OUT_W-1:0] out_q
);
  import ireq_pkg::*;

  logic                        vld_r, vld_nxt;
  logic        [OUT_W-1:0]     q_r, q_nxt;
  logic signed [EW-1:0]        near_lo;
  logic        [OUT_W-1:0]     near_res;
  logic        [ACC_WIDTH-1:0] sto_lim;
  logic        [ACC_WIDTH-1:0] sto_mag;
  logic        [OUT_W-1:0]     sto_res;

  always_comb begin
    near_lo = cfg.symmetric_clip ? EW'(Q_MIN_SYM) : EW'(Q_MIN);
    if (near_q > EW'(Q_MAX)) begin
      near_res = OUT_W'(Q_MAX);
    end else if (near_q < near_lo) begin
      near_res = near_lo[OUT_W-1:0];
    end else begin
      near_res = near_q[OUT_W-1:0];
    end

    if (sto_neg) begin
      sto_lim = cfg.symmetric_clip ? ACC_WIDTH'(Q_MAX) : ACC_WIDTH'(-Q_MIN);
    end else begin
      sto_lim = ACC_WIDTH'(Q_MAX);
    end
    sto_mag = (sto_q > sto_lim) ? sto_lim : sto_q;
    sto_res = sto_neg ? (OUT_W'(0) - sto_mag[OUT_W-1:0]) : sto_mag[OUT_W-1:0];

    vld_nxt = vld;
    q_nxt   = (cfg.rounding_mode == MODE_STOCH) ? sto_res : near_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_vld = vld_r;
  assign out_q   = q_r;

endmodule
`default_nettype wire
